/* src/bilinear_texture_sampler_defines.svh */
// assertion macros for the bilinear texture sampler
// used by the checker module, no other dependencies
`ifndef BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH

// property checked at every rising edge outside reset
`define BTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen at a rising edge outside reset
`define BTS_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* src/bts_pkg.sv */
// shared types and codes for the bilinear texture sampler
// no dependencies
`timescale 1ns / 1ps

package bts_pkg;

	localparam logic [1:0] EDGE_BORDER  = 2'd0;
	localparam logic [1:0] EDGE_CLAMP   = 2'd1;
	localparam logic [1:0] EDGE_WRAP    = 2'd2;
	localparam logic [1:0] EDGE_BORDER2 = 2'd3;

	localparam logic [1:0] REG_TEX_WIDTH   = 2'd0;
	localparam logic [1:0] REG_TEX_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_EDGE_MODE_X = 2'd2;
	localparam logic [1:0] REG_EDGE_MODE_Y = 2'd3;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef struct packed {
		logic       start;
		logic [1:0] mode;
	} axis_ctl_t;

	typedef struct packed {
		logic done;
		logic ok0;
		logic ok1;
	} axis_sts_t;

endpackage

/* src/bilinear_texture_sampler.sv */
// Bilinear texture sampler. A write word (func 0) stores one RGB8 texel and leaves
// the input free for the next word. In a sample word (func 1) the edge rule of each
// axis runs through a one-bit-per-cycle remainder unit over the IW integer bits of the
// scaled coordinate (14 at the default sizes), then the four neighbors are read one
// after another from the texel memory, each in a read-and-weight step, then an
// accumulate step. One sample is in flight at a time; a finished result waits in the
// output register while the next word is taken. Texels that were never written read as
// anything. Uses bts_pkg and bts_axis.
`timescale 1ns / 1ps

module bilinear_texture_sampler #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int UV_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  texel_x,
	input  logic [7:0]  texel_y,
	input  logic [7:0]  texel_red,
	input  logic [7:0]  texel_green,
	input  logic [7:0]  texel_blue,
	input  logic signed [19:0] coord_u,
	input  logic signed [19:0] coord_v,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue
);
	import bts_pkg::*;

	localparam int F = UV_FRAC_BITS;
	localparam int SWX = $clog2(MAX_WIDTH + 1);
	localparam int SWY = $clog2(MAX_HEIGHT + 1);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int EWX = (SWX > 9) ? SWX : 9;
	localparam int EWY = (SWY > 9) ? SWY : 9;
	localparam int PXW = 20 + SWX + 1;
	localparam int PYW = 20 + SWY + 1;
	localparam int IXW = PXW - F;
	localparam int IYW = PYW - F;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int WW = 2 * F + 2;
	localparam int ACW = 2 * F + 8;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_AXIS  = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_ACC   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [8:0] tex_width_q;
	logic [8:0] tex_height_q;
	logic [1:0] edge_mode_x_q;
	logic [1:0] edge_mode_y_q;
	logic       cfg_wr;

	logic [2:0] state_q;
	logic [1:0] k_q;
	logic       dx_q;
	logic       dy_q;
	logic       accept;

	logic signed [19:0]    u_q;
	logic signed [19:0]    v_q;
	logic signed [PXW-1:0] px_s1;
	logic signed [PYW-1:0] py_s1;
	logic [SWX-1:0]        wx;
	logic [SWY-1:0]        hy;

	axis_ctl_t      ctl_x;
	axis_ctl_t      ctl_y;
	axis_sts_t      sts_x;
	axis_sts_t      sts_y;
	logic [XW-1:0]  x0;
	logic [XW-1:0]  x1;
	logic [YW-1:0]  y0;
	logic [YW-1:0]  y1;

	logic [F:0]     wa;
	logic [F:0]     wb;
	logic [WW-1:0]  wt_s2;
	logic           ok_s2;
	logic [XW-1:0]  xs;
	logic [YW-1:0]  ys;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic           wr_en;
	logic [23:0]    rd_data_q;
	logic [23:0]    mem [DEPTH];
	logic [ACW-1:0] acc_r_q;
	logic [ACW-1:0] acc_g_q;
	logic [ACW-1:0] acc_b_q;
	logic [7:0]     cr;
	logic [7:0]     cg;
	logic [7:0]     cb;
	logic           out_valid_q;
	logic [15:0]    out_red_q;
	logic [15:0]    out_green_q;
	logic [15:0]    out_blue_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q <= 9'd256;
			tex_height_q <= 9'd256;
			edge_mode_x_q <= EDGE_BORDER;
			edge_mode_y_q <= EDGE_BORDER;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TEX_WIDTH:   tex_width_q <= pwdata[8:0];
				REG_TEX_HEIGHT:  tex_height_q <= pwdata[8:0];
				REG_EDGE_MODE_X: edge_mode_x_q <= pwdata[1:0];
				REG_EDGE_MODE_Y: edge_mode_y_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TEX_WIDTH:   prdata = {23'd0, tex_width_q};
			REG_TEX_HEIGHT:  prdata = {23'd0, tex_height_q};
			REG_EDGE_MODE_X: prdata = {30'd0, edge_mode_x_q};
			REG_EDGE_MODE_Y: prdata = {30'd0, edge_mode_y_q};
			default:         prdata = '0;
		endcase
	end

	// effective sizes
	always_comb begin
		if (tex_width_q == '0) begin
			wx = SWX'(1);
		end else if (EWX'(tex_width_q) > EWX'(MAX_WIDTH)) begin
			wx = SWX'(MAX_WIDTH);
		end else begin
			wx = SWX'(tex_width_q);
		end
		if (tex_height_q == '0) begin
			hy = SWY'(1);
		end else if (EWY'(tex_height_q) > EWY'(MAX_HEIGHT)) begin
			hy = SWY'(MAX_HEIGHT);
		end else begin
			hy = SWY'(tex_height_q);
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	// texel writes
	assign wr_en = accept && (func == FUNC_WRITE) &&
		(int'(texel_x) < MAX_WIDTH) && (int'(texel_y) < MAX_HEIGHT);
	assign wr_addr = AW'(int'(texel_y) * MAX_WIDTH + int'(texel_x));

	// neighbor select
	assign xs = k_q[0] ? x1 : x0;
	assign ys = k_q[1] ? y1 : y0;
	assign rd_addr = AW'(int'(ys) * MAX_WIDTH + int'(xs));
	assign wa = k_q[0] ? {1'b0, px_s1[F-1:0]} : ((F + 1)'(1) << F) - {1'b0, px_s1[F-1:0]};
	assign wb = k_q[1] ? {1'b0, py_s1[F-1:0]} : ((F + 1)'(1) << F) - {1'b0, py_s1[F-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {texel_red, texel_green, texel_blue};
		end
		if (state_q == ST_RD) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign ctl_x = '{start: state_q == ST_START, mode: edge_mode_x_q};
	assign ctl_y = '{start: state_q == ST_START, mode: edge_mode_y_q};

	bts_axis #(.SIZE_MAX(MAX_WIDTH), .IW(IXW), .SW(SWX), .XW(XW)) u_axis_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_x), .coord(px_s1[PXW-1:F]), .size(wx),
		.sts(sts_x), .idx0(x0), .idx1(x1)
	);

	bts_axis #(.SIZE_MAX(MAX_HEIGHT), .IW(IYW), .SW(SWY), .XW(YW)) u_axis_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_y), .coord(py_s1[PYW-1:F]), .size(hy),
		.sts(sts_y), .idx0(y0), .idx1(y1)
	);

	assign cr = ok_s2 ? rd_data_q[23:16] : 8'd0;
	assign cg = ok_s2 ? rd_data_q[15:8] : 8'd0;
	assign cb = ok_s2 ? rd_data_q[7:0] : 8'd0;

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			u_q <= coord_u;
			v_q <= coord_v;
		end
		if (state_q == ST_MUL) begin
			px_s1 <= u_q * signed'({1'b0, wx});
			py_s1 <= v_q * signed'({1'b0, hy});
		end
		if (state_q == ST_START) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end
		if (state_q == ST_RD) begin
			wt_s2 <= wa * wb;
			ok_s2 <= (k_q[0] ? sts_x.ok1 : sts_x.ok0) && (k_q[1] ? sts_y.ok1 : sts_y.ok0);
		end
		if (state_q == ST_ACC) begin
			acc_r_q <= acc_r_q + wt_s2 * cr;
			acc_g_q <= acc_g_q + wt_s2 * cg;
			acc_b_q <= acc_b_q + wt_s2 * cb;
		end
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			out_red_q <= acc_r_q[2*F+7:2*F-8];
			out_green_q <= acc_g_q[2*F+7:2*F-8];
			out_blue_q <= acc_b_q[2*F+7:2*F-8];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			dx_q <= 1'b0;
			dy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == ST_OUT) || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && func == FUNC_SAMPLE) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_START;
				ST_START: begin
					dx_q <= 1'b0;
					dy_q <= 1'b0;
					k_q <= '0;
					state_q <= ST_AXIS;
				end
				ST_AXIS: begin
					if (sts_x.done) begin
						dx_q <= 1'b1;
					end
					if (sts_y.done) begin
						dy_q <= 1'b1;
					end
					if ((dx_q || sts_x.done) && (dy_q || sts_y.done)) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_ACC;
				ST_ACC: begin
					k_q <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? ST_OUT : ST_RD;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_red = out_red_q;
	assign out_green = out_green_q;
	assign out_blue = out_blue_q;

endmodule

/* src/bts_axis.sv */
// resolves one axis position and its neighbor under the edge rule
// bit-serial remainder for wrap; uses bts_pkg
`timescale 1ns / 1ps

module bts_axis #(
	parameter int SIZE_MAX = 256,
	parameter int IW = 14,
	parameter int SW = $clog2(SIZE_MAX + 1),
	parameter int XW = $clog2(SIZE_MAX)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bts_pkg::axis_ctl_t    ctl,
	input  logic signed [IW-1:0]  coord,
	input  logic [SW-1:0]         size,
	output bts_pkg::axis_sts_t    sts,
	output logic [XW-1:0]         idx0,
	output logic [XW-1:0]         idx1
);
	import bts_pkg::*;

	localparam int CW = $clog2(IW + 1);
	localparam int LW = ((IW > SW) ? IW : SW) + 2;

	logic signed [IW-1:0] c_q;
	logic [SW-1:0]        size_q;
	logic [1:0]           mode_q;
	logic                 neg_q;
	logic [IW-1:0]        mag_q;
	logic [SW-1:0]        rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 ok0_q;
	logic                 ok1_q;
	logic [XW-1:0]        idx0_q;
	logic [XW-1:0]        idx1_q;

	logic [SW:0]          rem2;
	logic [SW:0]          rem_sub;
	logic signed [LW-1:0] ce;
	logic signed [LW-1:0] c1;
	logic signed [LW-1:0] sz;
	logic [SW-1:0]        wm;
	logic [SW-1:0]        w1;
	logic                 ok0_n;
	logic                 ok1_n;
	logic [XW-1:0]        idx0_n;
	logic [XW-1:0]        idx1_n;

	assign rem2 = {rem_q, mag_q[IW-1]};
	assign rem_sub = rem2 - {1'b0, size_q};

	assign ce = signed'({{(LW - IW){c_q[IW-1]}}, c_q});
	assign c1 = ce + LW'(1);
	assign sz = signed'({{(LW - SW){1'b0}}, size_q});
	assign wm = (neg_q && rem_q != '0) ? SW'(size_q - rem_q) : rem_q;
	assign w1 = (wm == SW'(size_q - SW'(1))) ? '0 : SW'(wm + SW'(1));

	always_comb begin
		ok0_n = 1'b1;
		ok1_n = 1'b1;
		idx0_n = ce[XW-1:0];
		idx1_n = c1[XW-1:0];
		unique case (mode_q)
			EDGE_CLAMP: begin
				if (ce < 0) begin
					idx0_n = '0;
				end else if (ce >= sz) begin
					idx0_n = XW'(size_q - SW'(1));
				end
				if (c1 < 0) begin
					idx1_n = '0;
				end else if (c1 >= sz) begin
					idx1_n = XW'(size_q - SW'(1));
				end
			end
			EDGE_WRAP: begin
				idx0_n = XW'(wm);
				idx1_n = XW'(w1);
			end
			default: begin
				ok0_n = (ce >= 0) && (ce < sz);
				ok1_n = (c1 >= 0) && (c1 < sz);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			c_q <= coord;
			size_q <= size;
			mode_q <= ctl.mode;
			neg_q <= coord[IW-1];
			mag_q <= coord[IW-1] ? IW'(-coord) : IW'(coord);
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			mag_q <= mag_q << 1;
			rem_q <= rem2 >= {1'b0, size_q} ? rem_sub[SW-1:0] : rem2[SW-1:0];
		end
		if (busy_q && cnt_q == '0) begin
			ok0_q <= ok0_n;
			ok1_q <= ok1_n;
			idx0_q <= idx0_n;
			idx1_q <= idx1_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(IW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	assign sts = '{done: done_q, ok0: ok0_q, ok1: ok1_q};
	assign idx0 = idx0_q;
	assign idx1 = idx1_q;

endmodule

/* src/bts_checker.sv */
// port-level checks for the bilinear texture sampler, bound to the top level
// uses bilinear_texture_sampler_defines.svh and bts_pkg
`timescale 1ns / 1ps
`include "bilinear_texture_sampler_defines.svh"

module bts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic func,
	input logic out_valid,
	input logic out_stall,
	input logic pready
);
	import bts_pkg::*;

	`BTS_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "result word dropped while stalled")
	`BTS_ASSERT(a_sample_busy, (in_valid && !in_stall && func == FUNC_SAMPLE) |=> in_stall, "sample word not held busy")
	`BTS_ASSERT(a_write_one, (in_valid && !in_stall && func == FUNC_WRITE) |=> !in_stall, "texel write took more than one cycle")
	`BTS_NEVER(a_pready, !pready, "pready low")

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (.*);

/* test/bilinear_texture_sampler_test.sv */
// self-checking testbench for the bilinear texture sampler: fills texel regions,
// sweeps sizes and edge rules over the register port, and checks filtered colors
// against an in-bench fixed-point filter. Depends on bts_pkg and the sampler RTL.
`timescale 1ns / 1ps

module bilinear_texture_sampler_test;
	import bts_pkg::*;

	localparam int MAX_DIM = 256;
	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} color_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic func = FUNC_WRITE;
	logic [7:0] texel_x = '0, texel_y = '0;
	logic [7:0] texel_red = '0, texel_green = '0, texel_blue = '0;
	logic signed [19:0] coord_u = '0, coord_v = '0;
	logic out_valid;
	logic out_stall = 1;
	logic [15:0] out_red, out_green, out_blue;

	logic [23:0] texel_mem [0:MAX_DIM*MAX_DIM-1];
	bit written [0:MAX_DIM*MAX_DIM-1];
	logic [8:0] cur_width = 9'd256, cur_height = 9'd256;
	logic [1:0] cur_mode_x = EDGE_BORDER, cur_mode_y = EDGE_BORDER;
	color_t expected_colors [$];
	int errors = 0;
	int cycles = 0;
	int samples_sent = 0, writes_sent = 0, colors_checked = 0;
	bit holding = 0;
	bit calm = 0;

	always #4 clk = ~clk;

	bilinear_texture_sampler DUT (.*);

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	function automatic longint eff_size(input logic [8:0] r);
		if (r == 0) return 1;
		if (r > MAX_DIM) return MAX_DIM;
		return r;
	endfunction

	// returns -1 when the border rule makes the neighbor black
	function automatic longint edge_resolve(input longint c, input longint size,
			input logic [1:0] mode);
		longint m;
		if (mode == EDGE_CLAMP) begin
			if (c < 0) return 0;
			if (c >= size) return size - 1;
			return c;
		end else if (mode == EDGE_WRAP) begin
			m = c % size;
			if (m < 0) m += size;
			return m;
		end
		if (c < 0 || c >= size) return -1;
		return c;
	endfunction

	function automatic color_t predict_filtered_color(input logic signed [19:0] u,
			input logic signed [19:0] v);
		longint w, h, pu, pv, ix, iy, rx, ry;
		longint unsigned fx, fy, one, wt, acc[3];
		logic [23:0] t;
		color_t c;
		one = 64'd1 << FRAC;
		w = eff_size(cur_width);
		h = eff_size(cur_height);
		pu = longint'(u) * w;
		pv = longint'(v) * h;
		fx = pu & (one - 1);
		fy = pv & (one - 1);
		ix = (pu - longint'(fx)) >>> FRAC;
		iy = (pv - longint'(fy)) >>> FRAC;
		acc[0] = 0; acc[1] = 0; acc[2] = 0;
		for (int k = 0; k < 4; k++) begin
			wt = ((k & 1) ? fx : one - fx) * ((k & 2) ? fy : one - fy);
			rx = edge_resolve(ix + (k & 1), w, cur_mode_x);
			ry = edge_resolve(iy + (k >> 1), h, cur_mode_y);
			t = (rx < 0 || ry < 0) ? 24'd0 : texel_mem[ry * MAX_DIM + rx];
			acc[0] += wt * t[23:16];
			acc[1] += wt * t[15:8];
			acc[2] += wt * t[7:0];
		end
		c.red = 16'(acc[0] >> (2 * FRAC - 8));
		c.green = 16'(acc[1] >> (2 * FRAC - 8));
		c.blue = 16'(acc[2] >> (2 * FRAC - 8));
		return c;
	endfunction

	task automatic send_word(input logic f, input logic [7:0] x, input logic [7:0] y,
			input logic [23:0] rgb, input logic signed [19:0] u, input logic signed [19:0] v);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		texel_x <= x;
		texel_y <= y;
		{texel_red, texel_green, texel_blue} <= rgb;
		coord_u <= u;
		coord_v <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (f == FUNC_WRITE) begin
			texel_mem[y * MAX_DIM + x] = rgb;
			written[y * MAX_DIM + x] = 1;
			writes_sent++;
		end else begin
			expected_colors.insert(expected_colors.size(), predict_filtered_color(u, v));
			samples_sent++;
		end
	endtask

	task automatic write_texel(input int x, input int y);
		send_word(FUNC_WRITE, 8'(x), 8'(y), 24'($urandom), 20'($urandom), 20'($urandom));
	endtask

	task automatic sample_at(input logic signed [19:0] u, input logic signed [19:0] v);
		send_word(FUNC_SAMPLE, 8'($urandom), 8'($urandom), 24'($urandom), u, v);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (expected_colors.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic hold_output(input int n);
		holding = 1;
		repeat (n) @(posedge clk);
		holding = 0;
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] mask;
		mask = (idx == REG_TEX_WIDTH || idx == REG_TEX_HEIGHT) ? 32'h1ff : 32'h3;
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		pwrite <= 0; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if ((prdata & mask) != (val & mask))
			report("register readback", prdata[15:0], val[15:0]);
		psel <= 0; penable <= 0;
		case (idx)
			REG_TEX_WIDTH: cur_width = val[8:0];
			REG_TEX_HEIGHT: cur_height = val[8:0];
			REG_EDGE_MODE_X: cur_mode_x = val[1:0];
			default: cur_mode_y = val[1:0];
		endcase
	endtask

	function automatic logic signed [19:0] random_coord();
		if ($urandom_range(99) < 25) return 20'($urandom);
		return 20'($signed($urandom_range(0, 4 * 65536)) - 98304);
	endfunction

	// fill what is still unwritten inside the new size so words outside the old size must survive,
	// then reconfigure and send count random texel writes and samples
	task automatic run_phase(input int wreg, input int hreg, input logic [1:0] mx,
			input logic [1:0] my, input int count);
		int w, h, r;
		w = int'(eff_size(9'(wreg)));
		h = int'(eff_size(9'(hreg)));
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				if (!written[y * MAX_DIM + x])
					write_texel(x, y);
		drain();
		reg_write(REG_TEX_WIDTH, wreg);
		reg_write(REG_TEX_HEIGHT, hreg);
		reg_write(REG_EDGE_MODE_X, 32'(mx));
		reg_write(REG_EDGE_MODE_Y, 32'(my));
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 10)
				write_texel($urandom_range(255), $urandom_range(255));
			else if (r < 25)
				write_texel($urandom_range(w - 1), $urandom_range(h - 1));
			else
				sample_at(random_coord(), random_coord());
		end
		drain();
	endtask

	task automatic test_border_extremes;
		logic signed [19:0] pts [6];
		pts = '{20'sh80000, 20'sh7ffff, 20'sh00000, 20'sh08000, 20'sh0ffff, 20'shfffff};
		run_phase(3, 2, EDGE_BORDER, EDGE_BORDER, 0);
		for (int i = 0; i < 6; i++) begin
			sample_at(pts[i], pts[(i + 2) % 6]);
			sample_at(pts[(i + 3) % 6], pts[i]);
		end
		drain();
	endtask

	task automatic test_clamp_wrap;
		run_phase(8, 8, EDGE_CLAMP, EDGE_WRAP, 40);
		run_phase(5, 7, EDGE_WRAP, EDGE_CLAMP, 40);
	endtask

	task automatic test_wide_row;
		calm = 1;
		run_phase(256, 1, EDGE_WRAP, EDGE_BORDER2, 50);
		calm = 0;
	endtask

	task automatic test_size_limits;
		run_phase(0, 300, EDGE_CLAMP, EDGE_WRAP, 50);
		run_phase(511, 1, EDGE_BORDER2, EDGE_CLAMP, 30);
	endtask

	task automatic test_backpressure;
		run_phase(12, 12, EDGE_WRAP, EDGE_WRAP, 0);
		fork
			hold_output(400);
		join_none
		for (int n = 0; n < 40; n++) sample_at(random_coord(), random_coord());
		drain();
		run_phase(12, 12, 2'($urandom_range(3)), 2'($urandom_range(3)), 50);
	endtask

	always @(posedge clk) begin
		color_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_colors.size() == 0) begin
				errors++;
				$display("unexpected result word at cycle %0d", cycles);
			end else begin
				e = expected_colors.pop_front();
				colors_checked++;
				if (out_red !== e.red) report("red", out_red, e.red);
				if (out_green !== e.green) report("green", out_green, e.green);
				if (out_blue !== e.blue) report("blue", out_blue, e.blue);
			end
		end
		out_stall <= holding || (!calm && $urandom_range(99) < 26);
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_border_extremes();
		test_clamp_wrap();
		test_wide_row();
		test_size_limits();
		test_backpressure();
		$display("%0d sample words and %0d texel writes sent, %0d colors checked",
			samples_sent, writes_sent, colors_checked);
		$display("sizes from 1 to 256 incl. zero and oversize, all edge rules, long output stall");
		if (errors == 0 && expected_colors.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* bilinear_texture_sampler.f */
+incdir+src
src/bts_pkg.sv
src/bts_axis.sv
src/bilinear_texture_sampler.sv
src/bts_checker.sv
test/bilinear_texture_sampler_test.sv
